[src/vtr_pkg.sv]
package vtr_pkg;

    // field widths
    localparam int DATA_W = 64;
    localparam int CMD_W  = 3;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;

    // table geometry and register reset
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam logic [CNT_W-1:0] BLOCKS_IN_USE_RST = 11'd1024;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_BUMP  = 3'd0,
        CMD_SET   = 3'd1,
        CMD_MAX   = 3'd2,
        CMD_MATCH = 3'd3,
        CMD_EQUAL = 3'd4
    } cmd_t;

    // sequencer to compare unit
    typedef struct packed {
        logic init;
        logic step;
        logic eq_mode;
    } vtr_unit_ctl_t;

    // compare unit to sequencer
    typedef struct packed {
        logic [DATA_W-1:0] max_val;
        logic [DATA_W-1:0] ref_val;
        logic              all_eq;
    } vtr_unit_sts_t;

endpackage

[src/block_version_table_range_ops_top.sv]
// Version table of TABLE_DEPTH 64-bit entries with range commands. After
// reset the block is busy while it clears the table. A request is taken
// when start is high and busy is low; its single result shows on status,
// version_out and all_match for exactly one cycle with done high, and must
// be captured then since the receiver cannot stall the block. The table
// sits in a single-port memory, one access per cycle, so a max, match or
// equal request reads its range, a set writes it and a bump reads then
// writes it; a request with an empty range, a range error or an unknown
// command goes straight to the result. busy stays high from acceptance until
// the cycle done is shown. blocks_in_use is to be written over the cfg
// channel while the block is idle; the block itself does not enforce it.
// cfg_ready is always high.
module block_version_table_range_ops_top #(
    parameter int TABLE_DEPTH = vtr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [vtr_pkg::CMD_W-1:0]  cmd,
    input  logic [vtr_pkg::IDX_W-1:0]  start_index,
    input  logic [vtr_pkg::CNT_W-1:0]  block_count,
    input  logic [vtr_pkg::DATA_W-1:0] operand_value,
    output logic                       done,
    output logic                       status,
    output logic [vtr_pkg::DATA_W-1:0] version_out,
    output logic                       all_match,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [vtr_pkg::CNT_W-1:0]  cfg_data
);

    localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [vtr_pkg::CNT_W-1:0]  blocks_in_use_reg;
    logic                       mem_we;
    logic [AddrW-1:0]           mem_addr;
    logic [vtr_pkg::DATA_W-1:0] mem_wdata;
    logic [vtr_pkg::DATA_W-1:0] mem_rdata;
    vtr_pkg::vtr_unit_ctl_t     unit_ctl;
    vtr_pkg::vtr_unit_sts_t     unit_sts;
    logic [vtr_pkg::DATA_W-1:0] unit_init_ref;

    // in-use count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= vtr_pkg::BLOCKS_IN_USE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            blocks_in_use_reg <= cfg_data;
        end
    end

    vtr_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AddrW       (AddrW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    vtr_unit u_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (unit_ctl),
        .init_ref (unit_init_ref),
        .rdata    (mem_rdata),
        .sts      (unit_sts)
    );

    vtr_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AddrW       (AddrW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .start_index   (start_index),
        .block_count   (block_count),
        .operand_value (operand_value),
        .blocks_in_use (blocks_in_use_reg),
        .mem_we        (mem_we),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .unit_ctl      (unit_ctl),
        .unit_init_ref (unit_init_ref),
        .unit_sts      (unit_sts),
        .done          (done),
        .status        (status),
        .version_out   (version_out),
        .all_match     (all_match)
    );

endmodule

[src/vtr_mem.sv]
module vtr_mem #(
    parameter int TABLE_DEPTH = vtr_pkg::TABLE_DEPTH_DEF,
    parameter int AddrW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AddrW-1:0]          addr,
    input  logic [vtr_pkg::DATA_W-1:0] wdata,
    output logic [vtr_pkg::DATA_W-1:0] rdata
);

    logic [vtr_pkg::DATA_W-1:0] mem [TABLE_DEPTH];
    logic [vtr_pkg::DATA_W-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/vtr_unit.sv]
module vtr_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vtr_pkg::vtr_unit_ctl_t     ctl,
    input  logic [vtr_pkg::DATA_W-1:0] init_ref,
    input  logic [vtr_pkg::DATA_W-1:0] rdata,
    output vtr_pkg::vtr_unit_sts_t     sts
);

    logic [vtr_pkg::DATA_W-1:0] max_reg, max_next;
    logic [vtr_pkg::DATA_W-1:0] ref_reg, ref_next;
    logic                       eq_reg, eq_next;
    logic                       first_reg, first_next;
    logic [vtr_pkg::DATA_W-1:0] ref_eff;

    // in equal mode the first entry read becomes the reference
    assign ref_eff = (ctl.eq_mode && first_reg) ? rdata : ref_reg;

    // running maximum and equality check
    always_comb
    begin
        max_next   = max_reg;
        ref_next   = ref_reg;
        eq_next    = eq_reg;
        first_next = first_reg;
        if (ctl.init)
        begin
            max_next   = '0;
            ref_next   = init_ref;
            eq_next    = 1'b1;
            first_next = 1'b1;
        end
        else if (ctl.step)
        begin
            if (rdata > max_reg)
            begin
                max_next = rdata;
            end
            eq_next    = eq_reg & (rdata == ref_eff);
            ref_next   = ref_eff;
            first_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg   <= '0;
            ref_reg   <= '0;
            eq_reg    <= 1'b1;
            first_reg <= 1'b1;
        end
        else
        begin
            max_reg   <= max_next;
            ref_reg   <= ref_next;
            eq_reg    <= eq_next;
            first_reg <= first_next;
        end
    end

    assign sts.max_val = max_reg;
    assign sts.ref_val = ref_reg;
    assign sts.all_eq  = eq_reg;

endmodule

[src/vtr_seq.sv]
module vtr_seq #(
    parameter int TABLE_DEPTH = vtr_pkg::TABLE_DEPTH_DEF,
    parameter int AddrW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [vtr_pkg::CMD_W-1:0]  cmd,
    input  logic [vtr_pkg::IDX_W-1:0]  start_index,
    input  logic [vtr_pkg::CNT_W-1:0]  block_count,
    input  logic [vtr_pkg::DATA_W-1:0] operand_value,
    input  logic [vtr_pkg::CNT_W-1:0]  blocks_in_use,
    output logic                       mem_we,
    output logic [AddrW-1:0]           mem_addr,
    output logic [vtr_pkg::DATA_W-1:0] mem_wdata,
    output vtr_pkg::vtr_unit_ctl_t     unit_ctl,
    output logic [vtr_pkg::DATA_W-1:0] unit_init_ref,
    input  vtr_pkg::vtr_unit_sts_t     unit_sts,
    output logic                       done,
    output logic                       status,
    output logic [vtr_pkg::DATA_W-1:0] version_out,
    output logic                       all_match
);

    localparam int DepthW = $clog2(TABLE_DEPTH + 1);
    localparam int CmpW   = (DepthW > vtr_pkg::CNT_W + 1) ? DepthW : vtr_pkg::CNT_W + 1;
    localparam logic [AddrW-1:0] LastAddr = AddrW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_RD_LAST,
        ST_WR,
        ST_FIN
    } state_t;

    state_t                      state_reg, state_next;
    logic [AddrW-1:0]            addr_reg, addr_next;
    logic [AddrW-1:0]            base_reg, base_next;
    logic [vtr_pkg::CNT_W-1:0]   remain_reg, remain_next;
    logic [vtr_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [vtr_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [vtr_pkg::DATA_W-1:0]  operand_reg, operand_next;
    logic                        err_reg, err_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic                        done_reg, done_next;
    logic                        status_reg, status_next;
    logic [vtr_pkg::DATA_W-1:0]  version_reg, version_next;
    logic                        match_reg, match_next;

    logic                        accept;
    logic [CmpW-1:0]             range_end;
    logic [CmpW-1:0]             limit;
    logic                        range_err;
    logic                        cmd_known;

    // range check against the saturated in-use count
    assign range_end = CmpW'(start_index) + CmpW'(block_count);
    assign limit     = (CmpW'(blocks_in_use) > CmpW'(TABLE_DEPTH)) ?
                       CmpW'(TABLE_DEPTH) : CmpW'(blocks_in_use);
    assign range_err = range_end > limit;
    assign cmd_known = cmd <= vtr_pkg::CMD_EQUAL;
    assign accept    = start && (state_reg == ST_IDLE);

    // compare unit control
    assign unit_ctl.init    = accept;
    assign unit_ctl.step    = rd_pend_reg;
    assign unit_ctl.eq_mode = (cmd_reg == vtr_pkg::CMD_EQUAL);
    assign unit_init_ref    = (cmd == vtr_pkg::CMD_MATCH) ? operand_value : '0;

    // memory port
    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WR);
    assign mem_addr  = addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 :
                       (cmd_reg == vtr_pkg::CMD_SET) ? operand_reg :
                       unit_sts.max_val + 64'd1;

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        base_next    = base_reg;
        remain_next  = remain_reg;
        count_next   = count_reg;
        cmd_next     = cmd_reg;
        operand_next = operand_reg;
        err_next     = err_reg;
        rd_pend_next = (state_reg == ST_RD);
        done_next    = 1'b0;
        status_next  = status_reg;
        version_next = version_reg;
        match_next   = match_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                addr_next = addr_reg + AddrW'(1);
                if (addr_reg == LastAddr)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = cmd;
                    operand_next = operand_value;
                    err_next     = range_err;
                    addr_next    = AddrW'(start_index);
                    base_next    = AddrW'(start_index);
                    remain_next  = block_count;
                    count_next   = block_count;
                    if (range_err || !cmd_known || (block_count == '0))
                    begin
                        state_next = ST_FIN;
                    end
                    else if (cmd == vtr_pkg::CMD_SET)
                    begin
                        state_next = ST_WR;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                addr_next   = addr_reg + AddrW'(1);
                remain_next = remain_reg - vtr_pkg::CNT_W'(1);
                if (remain_reg == vtr_pkg::CNT_W'(1))
                begin
                    state_next = ST_RD_LAST;
                end
            end
            ST_RD_LAST:
            begin
                if (cmd_reg == vtr_pkg::CMD_BUMP)
                begin
                    addr_next   = base_reg;
                    remain_next = count_reg;
                    state_next  = ST_WR;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_WR:
            begin
                addr_next   = addr_reg + AddrW'(1);
                remain_next = remain_reg - vtr_pkg::CNT_W'(1);
                if (remain_reg == vtr_pkg::CNT_W'(1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                done_next    = 1'b1;
                status_next  = 1'b0;
                version_next = '0;
                match_next   = 1'b0;
                state_next   = ST_IDLE;
                case (cmd_reg)
                    vtr_pkg::CMD_BUMP,
                    vtr_pkg::CMD_SET:
                    begin
                        status_next = err_reg;
                    end
                    vtr_pkg::CMD_MAX:
                    begin
                        status_next  = err_reg;
                        version_next = err_reg ? '1 : unit_sts.max_val;
                    end
                    vtr_pkg::CMD_MATCH:
                    begin
                        status_next = err_reg;
                        match_next  = !err_reg && unit_sts.all_eq;
                    end
                    vtr_pkg::CMD_EQUAL:
                    begin
                        status_next  = err_reg;
                        version_next = (!err_reg && unit_sts.all_eq) ? unit_sts.ref_val : '0;
                    end
                    default:
                    begin
                        status_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            base_reg    <= '0;
            remain_reg  <= '0;
            count_reg   <= '0;
            cmd_reg     <= '0;
            operand_reg <= '0;
            err_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= 1'b0;
            version_reg <= '0;
            match_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            base_reg    <= base_next;
            remain_reg  <= remain_next;
            count_reg   <= count_next;
            cmd_reg     <= cmd_next;
            operand_reg <= operand_next;
            err_reg     <= err_next;
            rd_pend_reg <= rd_pend_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            version_reg <= version_next;
            match_reg   <= match_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign version_out = version_reg;
    assign all_match   = match_reg;

endmodule
